### rtl/sst_pkg.sv
// shared types and constants for the sorted set table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int COUNT_W     = 5;
	localparam int POS_W       = 5;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADPOS   = 3'd4
	} status_t;

	// operation broadcast to every cell of the row
	typedef struct packed {
		logic                          ins;
		logic                          del;
		logic signed [VALUE_WIDTH-1:0] key;
	} op_t;

	// what a cell reports back
	typedef struct packed {
		logic valid;
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

`default_nettype wire

### rtl/sst_cell.sv
// one cell of the sorted row: holds a value and its valid bit
// depends on sst_pkg; shifts toward either neighbor on insert or remove
`timescale 1ns / 1ps
`default_nettype none

module sst_cell
	import sst_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire op_t                           op,
	input  wire logic signed [VALUE_WIDTH-1:0] left_val,
	input  wire logic                          left_valid,
	input  wire logic                          left_lt,
	input  wire logic signed [VALUE_WIDTH-1:0] right_val,
	input  wire logic                          right_valid,
	output logic signed [VALUE_WIDTH-1:0]      val,
	output cell_flags_t                        flags
);

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          valid_q;
	logic                          lt;

	assign lt    = valid_q && (val_q < op.key);
	assign val   = val_q;
	assign flags = '{valid: valid_q, lt: lt, eq: valid_q && (val_q == op.key)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.ins && !lt) begin
			valid_q <= valid_q | left_valid;
		end else if (op.del && !lt) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ins && !lt) begin
			// key lands at the first cell not below it, the rest move right
			val_q <= left_lt ? op.key : left_val;
		end else if (op.del && !lt) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

### rtl/sorted_set_table_core.sv
// Sorted set table: a row of CAPACITY cells holds distinct signed values in ascending
// order. Every command is broadcast to all cells, which compare against the key at once;
// an insert or remove shifts cells one place toward a neighbor. One beat is accepted per
// clock while the output is not stalled; its result is held in the output register. The
// combinational key compare across the cell row and the position mux set the rate and clock.
// depends on sst_pkg and sst_cell
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table_core
	import sst_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [CMD_W-1:0]              cmd,
	input  wire logic signed [VALUE_WIDTH-1:0] key_value,
	input  wire logic [POS_W-1:0]              position,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [STATUS_W-1:0]                status,
	output logic signed [VALUE_WIDTH-1:0]      read_value,
	output logic [COUNT_W-1:0]                 entry_count
);

	logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
	cell_flags_t                   cell_flg [CAPACITY];
	logic [CAPACITY-1:0]           eq_vec;
	op_t                           op;
	logic                          accept;
	logic                          is_ins, is_del, is_rd;
	logic                          dup, full, pos_ok;
	logic [COUNT_W-1:0]            count_q;
	logic [COUNT_W-1:0]            count_nxt;
	logic [POS_W-1:0]              pos_m1;
	status_t                       st_nxt;
	logic signed [VALUE_WIDTH-1:0] rv_nxt;

	logic                          out_valid_q;
	status_t                       status_q;
	logic signed [VALUE_WIDTH-1:0] read_value_q;
	logic [COUNT_W-1:0]            entry_count_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_ins   = accept && (cmd == CMD_INSERT);
	assign is_del   = accept && (cmd == CMD_REMOVE);
	assign is_rd    = accept && (cmd == CMD_READ);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			eq_vec[i] = cell_flg[i].eq;
		end
	end

	assign dup  = |eq_vec;
	assign full = cell_flg[CAPACITY-1].valid;

	assign op.ins = is_ins && !dup && !full;
	assign op.del = is_del && dup;
	assign op.key = key_value;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] lv, rv;
		logic                          lval, llt, rval;
		if (g == 0) begin : g_first
			assign lv   = '0;
			assign lval = 1'b1;
			assign llt  = 1'b1;
		end else begin : g_mid
			assign lv   = cell_val[g-1];
			assign lval = cell_flg[g-1].valid;
			assign llt  = cell_flg[g-1].lt;
		end
		if (g == CAPACITY - 1) begin : g_last
			assign rv   = '0;
			assign rval = 1'b0;
		end else begin : g_inner
			assign rv   = cell_val[g+1];
			assign rval = cell_flg[g+1].valid;
		end
		sst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.left_val   (lv),
			.left_valid (lval),
			.left_lt    (llt),
			.right_val  (rv),
			.right_valid(rval),
			.val        (cell_val[g]),
			.flags      (cell_flg[g])
		);
	end

	assign pos_m1 = position - POS_W'(1);
	assign pos_ok = (position != '0) && (position <= POS_W'(count_q));

	always_comb begin
		count_nxt = count_q;
		if (op.ins) begin
			count_nxt = count_q + COUNT_W'(1);
		end else if (op.del) begin
			count_nxt = count_q - COUNT_W'(1);
		end
	end

	always_comb begin
		st_nxt = ST_OK;
		rv_nxt = '0;
		if (is_ins) begin
			if (dup) begin
				st_nxt = ST_DUP;
			end else if (full) begin
				st_nxt = ST_FULL;
			end
		end else if (is_del) begin
			if (!dup) begin
				st_nxt = ST_NOTFOUND;
			end
		end else if (is_rd) begin
			if (pos_ok) begin
				rv_nxt = cell_val[pos_m1[IDX_W-1:0]];
			end else begin
				st_nxt = ST_BADPOS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= st_nxt;
			read_value_q  <= rv_nxt;
			entry_count_q <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

### rtl/sst_checker.sv
// port-level checks for the sorted set table, bound to the top level
// depends on sst_pkg
`timescale 1ns / 1ps
`default_nettype none

module sst_checker
	import sst_pkg::*;
(
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [CMD_W-1:0]              cmd,
	input wire logic signed [VALUE_WIDTH-1:0] key_value,
	input wire logic [POS_W-1:0]              position,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [STATUS_W-1:0]           status,
	input wire logic signed [VALUE_WIDTH-1:0] read_value,
	input wire logic [COUNT_W-1:0]            entry_count
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(entry_count))
		else $error("stalled result beat changed");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == COUNT_W'(CAPACITY))
		else $error("full reported below capacity");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> status == ST_OK)
		else $error("nonzero read value on failed beat");

	// input is taken whenever the output slot is free
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output slot");

endmodule

bind sorted_set_table_core sst_checker u_sst_checker (.*);

`default_nettype wire
